// File: design/ucpr_pkg.sv
package ucpr_pkg;

  localparam int CNT_W   = 16;
  localparam int LIM_W   = 16;
  localparam int DUTY_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int SCALE_W = 8;
  localparam int CMP_W   = (CNT_W > DUTY_W) ? CNT_W : DUTY_W;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_DATA_W = 24;

  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [DUTY_W-1:0] duty_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam count_t CNT_MAX = '1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PWM_PERIOD  = 3'd0,
    REG_SPEED_SCALE = 3'd1,
    REG_SLOW_STEP   = 3'd2,
    REG_FAST_STEP   = 3'd3,
    REG_TURN_TICKS  = 3'd4,
    REG_START_DUTY  = 3'd5
  } reg_idx_t;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_BYTE = 1'b1;

  localparam byte_t SPEED_MAX  = 8'd250;
  localparam byte_t CMD_SPORT  = 8'd251;
  localparam byte_t CMD_TRUCK  = 8'd252;
  localparam byte_t CMD_COAST  = 8'd253;
  localparam byte_t CMD_LEFT   = 8'd254;
  localparam byte_t CMD_RIGHT  = 8'd255;

  localparam logic [LIM_W-1:0]   RST_PWM_PERIOD  = 16'd9999;
  localparam logic [SCALE_W-1:0] RST_SPEED_SCALE = 8'd40;
  localparam logic [LIM_W-1:0]   RST_SLOW_STEP   = 16'd3000;
  localparam logic [LIM_W-1:0]   RST_FAST_STEP   = 16'd100;
  localparam logic [LIM_W-1:0]   RST_TURN_TICKS  = 16'd20000;
  localparam duty_t              RST_START_DUTY  = 16'd80;

  typedef struct packed {
    logic [LIM_W-1:0]   pwm_period;
    logic [SCALE_W-1:0] speed_scale;
    logic [LIM_W-1:0]   slow_step_ticks;
    logic [LIM_W-1:0]   fast_step_ticks;
    logic [LIM_W-1:0]   turn_ticks;
    duty_t              start_duty;
  } cfg_t;

  typedef struct packed {
    logic  turning;
    logic  sport_mode;
    duty_t duty_now;
    logic  steer_right;
    logic  steer_left;
    logic  pwm_out;
  } res_t;

  // saturate a 16-bit limit to the counter range
  function automatic count_t clip_lim(logic [LIM_W-1:0] v, logic at_least_one);
    logic [32:0] wide;
    count_t      r;
    wide = 33'(v);
    if (wide > 33'(CNT_MAX)) r = CNT_MAX;
    else r = count_t'(wide);
    if (at_least_one && (r == '0)) r = count_t'(1);
    return r;
  endfunction

endpackage

// File: design/uart_command_pwm_ramp_controller.sv
// Command-driven PWM ramp controller with steering pulses.
// Input stream: each transfer is a timer tick (in_tuser = 0) or a received
// command byte (in_tuser = 1, byte in in_tdata). Every input transfer yields
// exactly one output transfer carrying the PWM level, steering drives,
// current duty, ramp mode and turning flag after that request.
// Configuration: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
// write only while no item is in flight.
// Path: an accepted item sits in the input register; its result is then
// registered in the output register, which drives out_tdata and out_tvalid.
// Throughput: one item per cycle while the output is not stalled; the state
// update and result logic sit between the input register and the output register.
// Stall: while out_tready is low the output register holds its result, the
// input register holds its item, and in_tready drops once both are full.
// Reset (rst_n low, synchronous): registers return to their defaults, duty,
// target, counters and steering clear, truck mode, both channels empty.
module uart_command_pwm_ramp_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ucpr_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  input  logic                                in_tuser,   // [0] req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] pwm_out, [1] steer_left, [2] steer_right, [18:3] duty_now,
  // [19] sport_mode, [20] turning, [23:21] zero
  output logic [ucpr_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_we,
  input  logic [ucpr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [ucpr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  ucpr_pkg::cfg_t  cfg;
  ucpr_pkg::res_t  res;

  logic            in_valid_r;
  logic            in_req_r;
  ucpr_pkg::byte_t in_byte_r;
  logic            out_valid_r;
  ucpr_pkg::res_t  out_res_r;
  logic            advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  ucpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ucpr_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .req_type (in_req_r),
    .rx_byte  (in_byte_r),
    .cfg      (cfg),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ucpr_pkg::OUT_DATA_W'(out_res_r);

endmodule

// File: design/ucpr_cfg_regs.sv
module ucpr_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ucpr_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [ucpr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output ucpr_pkg::cfg_t                     cfg
);

  ucpr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period      <= ucpr_pkg::RST_PWM_PERIOD;
      cfg_r.speed_scale     <= ucpr_pkg::RST_SPEED_SCALE;
      cfg_r.slow_step_ticks <= ucpr_pkg::RST_SLOW_STEP;
      cfg_r.fast_step_ticks <= ucpr_pkg::RST_FAST_STEP;
      cfg_r.turn_ticks      <= ucpr_pkg::RST_TURN_TICKS;
      cfg_r.start_duty      <= ucpr_pkg::RST_START_DUTY;
    end else if (cfg_we) begin
      case (cfg_addr)
        ucpr_pkg::REG_PWM_PERIOD:  cfg_r.pwm_period      <= cfg_wdata;
        ucpr_pkg::REG_SPEED_SCALE: cfg_r.speed_scale     <= cfg_wdata[ucpr_pkg::SCALE_W-1:0];
        ucpr_pkg::REG_SLOW_STEP:   cfg_r.slow_step_ticks <= cfg_wdata;
        ucpr_pkg::REG_FAST_STEP:   cfg_r.fast_step_ticks <= cfg_wdata;
        ucpr_pkg::REG_TURN_TICKS:  cfg_r.turn_ticks      <= cfg_wdata;
        ucpr_pkg::REG_START_DUTY:  cfg_r.start_duty      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: design/ucpr_core.sv
module ucpr_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   advance,
  input  logic                   req_type,
  input  ucpr_pkg::byte_t        rx_byte,
  input  ucpr_pkg::cfg_t         cfg,
  output ucpr_pkg::res_t         res
);

  ucpr_pkg::duty_t  duty_r, duty_nxt;
  ucpr_pkg::byte_t  target_byte_r, target_byte_nxt;
  logic             fast_mode_r, fast_mode_nxt;
  ucpr_pkg::count_t pwm_count_r, pwm_count_nxt;
  ucpr_pkg::count_t step_count_r, step_count_nxt;
  ucpr_pkg::count_t turn_count_r, turn_count_nxt;
  logic             turn_dir_r, turn_dir_nxt;

  ucpr_pkg::count_t plim, slim, step_inc;
  ucpr_pkg::duty_t  target;
  logic             turning_nxt;

  always_comb begin
    plim     = ucpr_pkg::clip_lim(cfg.pwm_period, 1'b0);
    slim     = ucpr_pkg::clip_lim(fast_mode_r ? cfg.fast_step_ticks : cfg.slow_step_ticks,
                                  1'b1);
    step_inc = step_count_r + ucpr_pkg::count_t'(1);
    target   = ucpr_pkg::duty_t'(target_byte_r * cfg.speed_scale);

    duty_nxt        = duty_r;
    target_byte_nxt = target_byte_r;
    fast_mode_nxt   = fast_mode_r;
    pwm_count_nxt   = pwm_count_r;
    step_count_nxt  = step_count_r;
    turn_count_nxt  = turn_count_r;
    turn_dir_nxt    = turn_dir_r;

    if (req_type == ucpr_pkg::REQ_TICK) begin
      pwm_count_nxt = (pwm_count_r >= plim) ? '0 : pwm_count_r + ucpr_pkg::count_t'(1);
      if (turn_count_r != '0) begin
        turn_count_nxt = turn_count_r - ucpr_pkg::count_t'(1);
      end else if (step_inc >= slim) begin
        step_count_nxt = '0;
        if (duty_r < target) duty_nxt = duty_r + ucpr_pkg::duty_t'(1);
        else if (duty_r > target) duty_nxt = duty_r - ucpr_pkg::duty_t'(1);
      end else begin
        step_count_nxt = step_inc;
      end
    end else if (turn_count_r == '0) begin
      if (rx_byte <= ucpr_pkg::SPEED_MAX) begin
        target_byte_nxt = rx_byte;
      end else if (rx_byte <= ucpr_pkg::CMD_COAST) begin
        if (rx_byte == ucpr_pkg::CMD_SPORT) fast_mode_nxt = 1'b1;
        else if (rx_byte == ucpr_pkg::CMD_TRUCK) fast_mode_nxt = 1'b0;
        duty_nxt       = cfg.start_duty;
        step_count_nxt = '0;
      end else begin
        turn_dir_nxt   = (rx_byte == ucpr_pkg::CMD_RIGHT);
        turn_count_nxt = ucpr_pkg::clip_lim(cfg.turn_ticks, 1'b1);
      end
    end
  end

  always_comb begin
    turning_nxt     = (turn_count_nxt != '0);
    res.pwm_out     = (ucpr_pkg::CMP_W'(pwm_count_nxt) < ucpr_pkg::CMP_W'(duty_nxt));
    res.steer_left  = turning_nxt && !turn_dir_nxt;
    res.steer_right = turning_nxt && turn_dir_nxt;
    res.duty_now    = duty_nxt;
    res.sport_mode  = fast_mode_nxt;
    res.turning     = turning_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r        <= '0;
      target_byte_r <= '0;
      fast_mode_r   <= 1'b0;
      pwm_count_r   <= '0;
      step_count_r  <= '0;
      turn_count_r  <= '0;
      turn_dir_r    <= 1'b0;
    end else if (advance) begin
      duty_r        <= duty_nxt;
      target_byte_r <= target_byte_nxt;
      fast_mode_r   <= fast_mode_nxt;
      pwm_count_r   <= pwm_count_nxt;
      step_count_r  <= step_count_nxt;
      turn_count_r  <= turn_count_nxt;
      turn_dir_r    <= turn_dir_nxt;
    end
  end

endmodule

// File: bench/ramp_status_checker.sv
`timescale 1ns / 1ps

module ramp_status_checker
  import ucpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  byte_t                 in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           errors,
  output int unsigned           pending,
  output int unsigned           checked,
  output int unsigned           duty_moves,
  output int unsigned           pulses,
  output int unsigned           ignored
);

  cfg_t   regs;
  duty_t  duty;
  byte_t  speed_target;
  logic   sport;
  count_t pwm_cnt;
  count_t step_cnt;
  count_t turn_cnt;
  logic   turn_right;
  res_t   expected_status[$];

  task automatic step_controller(input logic kind, input byte_t b, output res_t r);
    count_t lim;
    duty_t  goal;
    if (kind == REQ_TICK) begin
      pwm_cnt = (pwm_cnt >= regs.pwm_period) ? '0 : count_t'(pwm_cnt + 1'b1);
      if (turn_cnt != '0) begin
        turn_cnt = turn_cnt - 1'b1;
      end else begin
        lim = sport ? regs.fast_step_ticks : regs.slow_step_ticks;
        if (lim == '0) lim = count_t'(1);
        step_cnt = step_cnt + 1'b1;
        if (step_cnt >= lim) begin
          step_cnt = '0;
          goal = speed_target * regs.speed_scale;
          if (duty != goal) duty_moves++;
          if (duty < goal) duty = duty + 1'b1;
          else if (duty > goal) duty = duty - 1'b1;
        end
      end
    end else if (turn_cnt != '0) begin
      ignored++;
    end else if (b <= SPEED_MAX) begin
      speed_target = b;
    end else if (b == CMD_LEFT || b == CMD_RIGHT) begin
      turn_right = (b == CMD_RIGHT);
      turn_cnt = (regs.turn_ticks == '0) ? count_t'(1) : regs.turn_ticks;
      pulses++;
    end else begin
      if (b == CMD_SPORT) sport = 1'b1;
      else if (b == CMD_TRUCK) sport = 1'b0;
      duty = regs.start_duty;
      step_cnt = '0;
    end
    r.pwm_out     = (pwm_cnt < duty);
    r.steer_left  = (turn_cnt != '0) && !turn_right;
    r.steer_right = (turn_cnt != '0) && turn_right;
    r.duty_now    = duty;
    r.sport_mode  = sport;
    r.turning     = (turn_cnt != '0);
  endtask

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      regs.pwm_period      = RST_PWM_PERIOD;
      regs.speed_scale     = RST_SPEED_SCALE;
      regs.slow_step_ticks = RST_SLOW_STEP;
      regs.fast_step_ticks = RST_FAST_STEP;
      regs.turn_ticks      = RST_TURN_TICKS;
      regs.start_duty      = RST_START_DUTY;
      duty         = '0;
      speed_target = '0;
      sport        = 1'b0;
      pwm_cnt      = '0;
      step_cnt     = '0;
      turn_cnt     = '0;
      turn_right   = 1'b0;
      expected_status.delete();
      pending = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = res_t'(out_tdata[$bits(res_t)-1:0]);
        if (expected_status.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual %h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_status.pop_front();
          cmp_field("pwm_out", want.pwm_out, got.pwm_out);
          cmp_field("steer_left", want.steer_left, got.steer_left);
          cmp_field("steer_right", want.steer_right, got.steer_right);
          cmp_field("duty_now", want.duty_now, got.duty_now);
          cmp_field("sport_mode", want.sport_mode, got.sport_mode);
          cmp_field("turning", want.turning, got.turning);
          cmp_field("pad", 0, out_tdata[OUT_DATA_W-1:$bits(res_t)]);
          checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        step_controller(in_tuser, in_tdata, want);
        expected_status.push_back(want);
      end
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_PWM_PERIOD:  regs.pwm_period      = cfg_wdata;
          REG_SPEED_SCALE: regs.speed_scale     = cfg_wdata[SCALE_W-1:0];
          REG_SLOW_STEP:   regs.slow_step_ticks = cfg_wdata;
          REG_FAST_STEP:   regs.fast_step_ticks = cfg_wdata;
          REG_TURN_TICKS:  regs.turn_ticks      = cfg_wdata;
          REG_START_DUTY:  regs.start_duty      = cfg_wdata;
          default: ;
        endcase
      end
      pending = expected_status.size();
    end
  end

endmodule

// File: bench/uart_command_pwm_ramp_controller_tb.sv
`timescale 1ns / 1ps

module uart_command_pwm_ramp_controller_tb;
  import ucpr_pkg::*;

  localparam int NUM_PHASES     = 7;
  localparam int PHASE_ITEMS    = 290;
  localparam int LAST_ITEMS     = 150;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 10;

  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE_HI = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  byte_t                 in_tdata;   // [7:0] rx_byte
  logic                  in_tuser;   // [0] req_type
  logic                  out_tvalid;
  logic                  out_tready;
  // [0] pwm_out, [1] steer_left, [2] steer_right, [18:3] duty_now,
  // [19] sport_mode, [20] turning, [23:21] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned duty_moves;
  int unsigned pulses;
  int unsigned ignored;
  int unsigned ticks_sent;
  int unsigned bytes_sent;
  int unsigned hold_asks;
  int unsigned quiet;

  always #5 clk = ~clk;

  uart_command_pwm_ramp_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  ramp_status_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .duty_moves (duty_moves),
    .pulses     (pulses),
    .ignored    (ignored)
  );

  task automatic offer(input logic kind, input byte_t b);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (kind == REQ_TICK) ticks_sent++;
    else bytes_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(negedge clk);
  endtask

  task automatic load_regs(input cfg_t c);
    write_reg(REG_PWM_PERIOD, c.pwm_period);
    write_reg(REG_SPEED_SCALE, {8'($urandom), c.speed_scale});
    write_reg(REG_SLOW_STEP, c.slow_step_ticks);
    write_reg(REG_FAST_STEP, c.fast_step_ticks);
    write_reg(REG_TURN_TICKS, c.turn_ticks);
    write_reg(REG_START_DUTY, c.start_duty);
    write_reg(ADDR_SPARE_LO, CFG_DATA_W'($urandom));
    write_reg(ADDR_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic cfg_t phase_regs(int p);
    cfg_t c;
    case (p)
      0: c = '{pwm_period: 16'd0, speed_scale: 8'd1, slow_step_ticks: 16'd0,
               fast_step_ticks: 16'd0, turn_ticks: 16'd0, start_duty: 16'd0};
      1: c = '{pwm_period: 16'd1, speed_scale: 8'd255, slow_step_ticks: 16'd3,
               fast_step_ticks: 16'hFFFF, turn_ticks: 16'd5, start_duty: 16'hFFFF};
      2: c = '{pwm_period: 16'hFFFF, speed_scale: 8'd0, slow_step_ticks: 16'd1,
               fast_step_ticks: 16'd2, turn_ticks: 16'd1, start_duty: 16'd100};
      NUM_PHASES - 1:
         c = '{pwm_period: 16'hFFFF, speed_scale: 8'd255, slow_step_ticks: 16'hFFFF,
               fast_step_ticks: 16'd1, turn_ticks: 16'hFFFF, start_duty: 16'hFFFF};
      default: begin
        c.pwm_period      = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(24));
        c.speed_scale     = 8'($urandom_range(6));
        c.slow_step_ticks = 16'($urandom_range(6));
        c.fast_step_ticks = 16'($urandom_range(3));
        c.turn_ticks      = 16'($urandom_range(10));
        c.start_duty      = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(80));
      end
    endcase
    return c;
  endfunction

  // mostly ticks; speed bytes biased small so the ramp can land on target
  task automatic random_req(output logic kind, output byte_t b);
    int unsigned r;
    r    = $urandom_range(99);
    kind = REQ_BYTE;
    b    = byte_t'($urandom);
    if (r < 78) kind = REQ_TICK;
    else if (r < 83) b = byte_t'($urandom_range(12));
    else if (r < 88) b = byte_t'($urandom_range(SPEED_MAX));
    else if (r < 94) b = byte_t'($urandom_range(CMD_SPORT, CMD_COAST));
    else if (r < 98) b = ($urandom_range(1) != 0) ? CMD_LEFT : CMD_RIGHT;
  endtask

  initial begin : sink
    int unsigned span;
    int unsigned stall_pct;
    int unsigned held;
    int unsigned hold_left;
    span       = 0;
    stall_pct  = 0;
    held       = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != held) begin
        held      = hold_asks;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          span = $urandom_range(4, 60);
          case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        span--;
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("uart_command_pwm_ramp_controller regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic        kind;
    byte_t       b;
    int unsigned burst;
    bit          gappy;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = REQ_TICK;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default registers, no pulses
    offer(REQ_TICK, 8'hA5);
    offer(REQ_BYTE, SPEED_MAX);
    offer(REQ_BYTE, 8'd0);
    offer(REQ_BYTE, CMD_SPORT);
    offer(REQ_TICK, 8'h5A);
    offer(REQ_BYTE, CMD_COAST);
    offer(REQ_BYTE, CMD_TRUCK);
    settle();
    load_regs('{pwm_period: 16'd3, speed_scale: 8'd2, slow_step_ticks: 16'd2,
                fast_step_ticks: 16'd1, turn_ticks: 16'd3, start_duty: 16'd6});
    offer(REQ_BYTE, 8'd0);
    repeat (3) offer(REQ_TICK, 8'hFF);
    offer(REQ_BYTE, CMD_SPORT);
    offer(REQ_BYTE, 8'd5);
    repeat (2) offer(REQ_TICK, 8'h00);
    offer(REQ_BYTE, CMD_LEFT);
    offer(REQ_BYTE, SPEED_MAX);
    offer(REQ_BYTE, CMD_RIGHT);
    repeat (2) offer(REQ_TICK, 8'h3C);
    offer(REQ_BYTE, CMD_RIGHT);
    repeat (3) offer(REQ_TICK, 8'hC3);
    offer(REQ_BYTE, CMD_COAST);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      load_regs(phase_regs(p));
      gappy = (p % 3 != 1);
      if (!gappy) hold_asks++;
      burst = $urandom_range(1, 30);
      for (int i = 0; i < ((p == NUM_PHASES - 1) ? LAST_ITEMS : PHASE_ITEMS); i++) begin
        random_req(kind, b);
        offer(kind, b);
        if (gappy) begin
          burst--;
          if (burst == 0) begin
            in_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst = $urandom_range(1, 30);
          end
        end
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d ticks and %0d command bytes over %0d register settings, %0d results checked.",
             ticks_sent, bytes_sent, NUM_PHASES + 2, checked);
    $display("Duty stepped %0d times, %0d steering pulses, %0d bytes dropped during pulses.",
             duty_moves, pulses, ignored);
    if (errors == 0 && pending == 0) begin
      $display("uart_command_pwm_ramp_controller regression: pass");
    end else begin
      $display("uart_command_pwm_ramp_controller regression: fail");
    end
    $finish;
  end

endmodule
